>>> sv/mfb64_pkg.sv
// Shared types, codes and constant tables of the marker-framed base64 demux.
// No dependencies; imported by mfb64_dp, mfb64_ctrl and the top level.
package mfb64_pkg;

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_HEADER = 2'd1;
  localparam logic [1:0] MODE_DATA   = 2'd2;

  localparam logic [2:0] KIND_PASS  = 3'd0;
  localparam logic [2:0] KIND_NAME  = 3'd1;
  localparam logic [2:0] KIND_DEC   = 3'd2;
  localparam logic [2:0] KIND_DONE  = 3'd3;
  localparam logic [2:0] KIND_ABORT = 3'd4;
  localparam logic [2:0] KIND_BAD   = 3'd5;

  // result source selects
  localparam logic [2:0] ESEL_MARK  = 3'd0;
  localparam logic [2:0] ESEL_CHAR  = 3'd1;
  localparam logic [2:0] ESEL_NAME  = 3'd2;
  localparam logic [2:0] ESEL_DEC   = 3'd3;
  localparam logic [2:0] ESEL_DONE  = 3'd4;
  localparam logic [2:0] ESEL_ABORT = 3'd5;
  localparam logic [2:0] ESEL_BAD   = 3'd6;

  localparam logic [3:0] BEGIN_LEN = 4'd13;
  localparam logic [3:0] END_LEN   = 4'd14;
  localparam int         NW        = 7;
  localparam logic [NW-1:0] NAME_MAX = 7'd64;

  localparam logic [6:0] SX_PAD = 7'd64;
  localparam logic [6:0] SX_BAD = 7'd65;

  typedef struct packed {
    logic       cap;
    logic       idle_inc;
    logic       idle_zero;
    logic       clear_xfer;
    logic       match_inc;
    logic       match_set1;
    logic       match_zero;
    logic       mode_set;
    logic [1:0] mode_val;
    logic       hdr_start;
    logic       hdr_write;
    logic       name_setup;
    logic       rel_start;
    logic       rel_adv;
    logic       feed;
    logic       feed_src;
    logic       dec_adv;
    logic       name_rd;
    logic       name_adv;
    logic       emit;
    logic [2:0] emit_sel;
    logic       flush;
  } cmd_t;

  typedef struct packed {
    logic       req_tick;
    logic [1:0] mode;
    logic       c_eq_mark;
    logic       c_eq_first;
    logic       match_end;
    logic       rel_more;
    logic       hdr_full;
    logic       hdr_close;
    logic       name_ok;
    logic       f_complete;
    logic       f_bad;
    logic       dec_last;
    logic       name_last;
    logic       timeout_hit;
    logic       can_emit;
    logic       out_free;
    logic       pend_valid;
  } sts_t;

  function automatic logic [7:0] begin_mark(input logic [3:0] i);
    logic [7:0] b;
    case (i)
      4'd0, 4'd1, 4'd2: b = 8'h3C;
      4'd3:  b = 8'h52;
      4'd4, 4'd5: b = 8'h4F;
      4'd6:  b = 8'h4B;
      4'd7:  b = 8'h5F;
      4'd8:  b = 8'h46;
      4'd9:  b = 8'h49;
      4'd10: b = 8'h4C;
      4'd11: b = 8'h45;
      4'd12: b = 8'h3A;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] end_mark(input logic [3:0] i);
    logic [7:0] b;
    case (i)
      4'd0, 4'd1, 4'd2: b = 8'h3C;
      4'd3:  b = 8'h52;
      4'd4, 4'd5: b = 8'h4F;
      4'd6:  b = 8'h4B;
      4'd7:  b = 8'h5F;
      4'd8:  b = 8'h45;
      4'd9:  b = 8'h4F;
      4'd10: b = 8'h46;
      4'd11, 4'd12, 4'd13: b = 8'h3E;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // base64 alphabet lookup; SX_PAD for '=', SX_BAD outside the alphabet
  function automatic logic [6:0] sextet(input logic [7:0] c);
    logic [7:0] r;
    if (c >= 8'h41 && c <= 8'h5A) r = c - 8'h41;
    else if (c >= 8'h61 && c <= 8'h7A) r = c - 8'h47;
    else if (c >= 8'h30 && c <= 8'h39) r = c + 8'h04;
    else if (c == 8'h2B) r = 8'd62;
    else if (c == 8'h2F) r = 8'd63;
    else if (c == 8'h3D) r = {1'b0, SX_PAD};
    else r = {1'b0, SX_BAD};
    return r[6:0];
  endfunction

endpackage

>>> sv/mfb64_dp.sv
// Datapath: captured item, marker match, header memory, quartet decoder,
// counters and the pending/output result registers. Uses mfb64_pkg.
module mfb64_dp #(
  parameter int HEADER_DEPTH = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [31:0]       cfg_wr_data,
  input  logic [15:0]       in_data,
  input  logic              in_tick,
  input  mfb64_pkg::cmd_t   cmd,
  output mfb64_pkg::sts_t   sts,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [2:0]        out_kind,
  output logic [7:0]        out_value,
  output logic [31:0]       out_count,
  output logic              out_last
);
  import mfb64_pkg::*;

  localparam int HW = $clog2(HEADER_DEPTH);
  localparam int CW = (HW > NW) ? HW : NW;

  logic [7:0]    c;
  logic          rdy;
  logic          tick;
  logic [31:0]   timeout;
  logic [1:0]    mode;
  logic [3:0]    match;
  logic [3:0]    rel_idx;
  logic [7:0]    hmem [HEADER_DEPTH];
  logic [HW-1:0] hlen;
  logic [1:0]    gt_run;
  logic [HW-1:0] scan;
  logic          found;
  logic [NW-1:0] name_len;
  logic [NW-1:0] name_i;
  logic [7:0]    rdata;
  logic [5:0]    qs [3];
  logic [1:0]    qfill;
  logic [2:0]    qpad;
  logic          qbad;
  logic [23:0]   dec_word;
  logic [1:0]    dec_cnt;
  logic [1:0]    dec_i;
  logic [31:0]   total;
  logic [31:0]   idle;
  logic          pend_valid;
  logic [2:0]    pend_kind;
  logic [7:0]    pend_value;
  logic [31:0]   pend_count;

  logic [7:0]    mk;
  logic [7:0]    fc;
  logic          f_skip;
  logic [6:0]    sx;
  logic          is_pad;
  logic          is_bad;
  logic [5:0]    sv;
  logic [3:0]    pad_fin;
  logic          bad_fin;
  logic [1:0]    cnt_new;
  logic [HW-1:0] scan_eff;
  logic [HW-1:0] lenm2;
  logic [HW-1:0] name_raw;
  logic [CW-1:0] nr_ext;
  logic [NW-1:0] name_len_new;
  logic [31:0]   idle_new;
  logic [7:0]    dec_byte;
  logic [2:0]    new_kind;
  logic [7:0]    new_value;
  logic [31:0]   new_count;
  logic          out_load;

  always_comb begin
    mk = (mode == MODE_DATA) ? end_mark(match) : begin_mark(match);
    fc = cmd.feed_src ? c : end_mark(rel_idx);
    f_skip = (fc == 8'h0D) || (fc == 8'h0A) || (fc == 8'h20);
    sx = sextet(fc);
    is_pad = (sx == SX_PAD);
    is_bad = (sx == SX_BAD);
    sv = (is_pad || is_bad) ? 6'd0 : sx[5:0];
    pad_fin = {is_pad, qpad};
    bad_fin = qbad || is_bad;
    cnt_new = (pad_fin == 4'd0) ? 2'd3 : ((pad_fin == 4'd8) ? 2'd2 : 2'd1);
    scan_eff = found ? scan : scan + 1'b1;
    lenm2 = hlen - HW'(2);
    name_raw = (scan_eff < lenm2) ? scan_eff : lenm2;
    nr_ext = CW'(name_raw);
    name_len_new = (nr_ext > CW'(NAME_MAX)) ? NAME_MAX : NW'(nr_ext);
    idle_new = (&idle) ? idle : idle + 32'd1;
    case (dec_i)
      2'd0:    dec_byte = dec_word[23:16];
      2'd1:    dec_byte = dec_word[15:8];
      default: dec_byte = dec_word[7:0];
    endcase
  end

  always_comb begin
    sts.req_tick    = tick;
    sts.mode        = mode;
    sts.c_eq_mark   = (c == mk);
    sts.c_eq_first  = (c == ((mode == MODE_DATA) ? end_mark(4'd0) : begin_mark(4'd0)));
    sts.match_end   = ({1'b0, match} + 5'd1) >=
                      {1'b0, (mode == MODE_DATA) ? END_LEN : BEGIN_LEN};
    sts.rel_more    = rel_idx < match;
    sts.hdr_full    = hlen >= HW'(HEADER_DEPTH - 1);
    sts.hdr_close   = (c == 8'h3E) && (gt_run >= 2'd2);
    sts.name_ok     = rdy && (name_raw != '0);
    sts.f_complete  = !f_skip && (qfill == 2'd3);
    sts.f_bad       = bad_fin || !((pad_fin == 4'd0) || (pad_fin == 4'd8) ||
                                   (pad_fin == 4'd12));
    sts.dec_last    = (dec_i + 2'd1) == dec_cnt;
    sts.name_last   = (name_i + 1'b1) == name_len;
    sts.timeout_hit = idle_new > timeout;
    sts.out_free    = !out_valid || out_ready;
    sts.can_emit    = !pend_valid || !out_valid || out_ready;
    sts.pend_valid  = pend_valid;
  end

  always_comb begin
    new_kind  = KIND_PASS;
    new_value = 8'h00;
    new_count = 32'd0;
    case (cmd.emit_sel)
      ESEL_MARK:  new_value = begin_mark(rel_idx);
      ESEL_CHAR:  new_value = c;
      ESEL_NAME: begin
        new_kind  = KIND_NAME;
        new_value = rdata;
      end
      ESEL_DEC: begin
        new_kind  = KIND_DEC;
        new_value = dec_byte;
      end
      ESEL_DONE: begin
        new_kind  = KIND_DONE;
        new_count = total;
      end
      ESEL_ABORT: new_kind = KIND_ABORT;
      ESEL_BAD:   new_kind = KIND_BAD;
      default:    new_kind = KIND_PASS;
    endcase
  end

  // captured item and config register
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      c    <= in_data[7:0];
      rdy  <= in_data[8];
      tick <= in_tick;
    end
    if (rst) begin
      timeout <= 32'd30000;
    end else if (cfg_wr_en) begin
      timeout <= cfg_wr_data;
    end
  end

  // mode, match and transfer counters
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_NORMAL;
      match  <= 4'd0;
      qfill  <= 2'd0;
      qpad   <= 3'd0;
      qbad   <= 1'b0;
      total  <= 32'd0;
      idle   <= 32'd0;
      hlen   <= '0;
    end else begin
      if (cmd.clear_xfer) begin
        mode  <= MODE_NORMAL;
        match <= 4'd0;
        qfill <= 2'd0;
        qpad  <= 3'd0;
        qbad  <= 1'b0;
        total <= 32'd0;
        idle  <= 32'd0;
      end else begin
        if (cmd.match_set1) match <= 4'd1;
        else if (cmd.match_zero) match <= 4'd0;
        else if (cmd.match_inc) match <= match + 4'd1;
        if (cmd.idle_inc) idle <= idle_new;
        else if (cmd.idle_zero) idle <= 32'd0;
        if (cmd.feed && !f_skip) begin
          if (qfill != 2'd3) begin
            qpad[qfill] <= is_pad;
            qbad        <= bad_fin;
            qfill       <= qfill + 2'd1;
          end else begin
            qfill <= 2'd0;
            qpad  <= 3'd0;
            qbad  <= 1'b0;
            if (!sts.f_bad) total <= total + 32'(cnt_new);
          end
        end
      end
      if (cmd.mode_set) mode <= cmd.mode_val;
      if (cmd.hdr_start) hlen <= '0;
      else if (cmd.hdr_write) hlen <= hlen + 1'b1;
    end
  end

  // header tracking, sextet store, decode and name walk
  always_ff @(posedge clk) begin
    if (cmd.rel_start) rel_idx <= 4'd0;
    else if (cmd.rel_adv) rel_idx <= rel_idx + 4'd1;
    if (cmd.hdr_start) begin
      gt_run <= 2'd0;
      scan   <= '0;
      found  <= 1'b0;
    end else if (cmd.hdr_write) begin
      hmem[hlen] <= c;
      gt_run <= (c == 8'h3E) ? ((gt_run == 2'd3) ? 2'd3 : gt_run + 2'd1) : 2'd0;
      if (!found) begin
        if ((c == 8'h3B) || (c == 8'h00)) found <= 1'b1;
        else scan <= scan + 1'b1;
      end
    end
    if (cmd.feed && !f_skip) begin
      if (qfill != 2'd3) begin
        qs[qfill] <= sv;
      end else begin
        dec_word <= {qs[0], qs[1], qs[2], sv};
        dec_cnt  <= cnt_new;
        dec_i    <= 2'd0;
      end
    end else if (cmd.dec_adv) begin
      dec_i <= dec_i + 2'd1;
    end
    if (cmd.name_setup) begin
      name_len <= name_len_new;
      name_i   <= '0;
    end else if (cmd.name_adv) begin
      name_i <= name_i + 1'b1;
    end
    if (cmd.name_rd) rdata <= hmem[HW'(name_i)];
  end

  // hold the newest result back until the next one or the end of the item marks it
  assign out_load = (cmd.emit && pend_valid) || cmd.flush;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.emit) pend_valid <= 1'b1;
      else if (cmd.flush) pend_valid <= 1'b0;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind  <= pend_kind;
      out_value <= pend_value;
      out_count <= pend_count;
      out_last  <= cmd.flush;
    end
    if (cmd.emit) begin
      pend_kind  <= new_kind;
      pend_value <= new_value;
      pend_count <= new_count;
    end
  end

endmodule

>>> sv/mfb64_ctrl.sv
// Controller state machine: sequences one item at a time through the
// datapath by command and status structs. Uses mfb64_pkg.
module mfb64_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  mfb64_pkg::sts_t sts,
  output mfb64_pkg::cmd_t cmd
);
  import mfb64_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_RELN  = 4'd2;
  localparam logic [3:0] S_RELD  = 4'd3;
  localparam logic [3:0] S_FEEDC = 4'd4;
  localparam logic [3:0] S_DEC   = 4'd5;
  localparam logic [3:0] S_NRD   = 4'd6;
  localparam logic [3:0] S_NOUT  = 4'd7;
  localparam logic [3:0] S_FLUSH = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       ret_rel;
  logic       ret_rel_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.feed_src = (state == S_FEEDC);
    state_next = state;
    ret_rel_next = ret_rel;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.req_tick) begin
          if (sts.mode == MODE_DATA) begin
            if (!sts.timeout_hit) begin
              cmd.idle_inc = 1'b1;
              state_next = S_FLUSH;
            end else if (sts.can_emit) begin
              cmd.emit = 1'b1;
              cmd.emit_sel = ESEL_ABORT;
              cmd.clear_xfer = 1'b1;
              state_next = S_FLUSH;
            end
          end else begin
            state_next = S_FLUSH;
          end
        end else if (sts.mode == MODE_HEADER) begin
          state_next = S_FLUSH;
          if (sts.hdr_full) begin
            // overlong header: drop silently
            cmd.mode_set = 1'b1;
            cmd.mode_val = MODE_NORMAL;
            cmd.match_zero = 1'b1;
          end else begin
            cmd.hdr_write = 1'b1;
            if (sts.hdr_close) begin
              cmd.match_zero = 1'b1;
              cmd.mode_set = 1'b1;
              if (sts.name_ok) begin
                cmd.name_setup = 1'b1;
                cmd.clear_xfer = 1'b1;
                cmd.mode_val = MODE_DATA;
                state_next = S_NRD;
              end else begin
                cmd.mode_val = MODE_NORMAL;
              end
            end
          end
        end else if (sts.mode == MODE_DATA) begin
          cmd.idle_zero = 1'b1;
          if (!sts.c_eq_mark) begin
            cmd.rel_start = 1'b1;
            state_next = S_RELD;
          end else if (!sts.match_end) begin
            cmd.match_inc = 1'b1;
            state_next = S_FLUSH;
          end else if (sts.can_emit) begin
            cmd.emit = 1'b1;
            cmd.emit_sel = ESEL_DONE;
            cmd.clear_xfer = 1'b1;
            state_next = S_FLUSH;
          end
        end else begin
          if (!sts.c_eq_mark) begin
            cmd.rel_start = 1'b1;
            state_next = S_RELN;
          end else if (sts.match_end) begin
            cmd.hdr_start = 1'b1;
            cmd.mode_set = 1'b1;
            cmd.mode_val = MODE_HEADER;
            cmd.match_zero = 1'b1;
            state_next = S_FLUSH;
          end else begin
            cmd.match_inc = 1'b1;
            state_next = S_FLUSH;
          end
        end
      end
      S_RELN: begin
        if (sts.rel_more) begin
          if (sts.can_emit) begin
            cmd.emit = 1'b1;
            cmd.emit_sel = ESEL_MARK;
            cmd.rel_adv = 1'b1;
          end
        end else if (sts.c_eq_first) begin
          cmd.match_set1 = 1'b1;
          state_next = S_FLUSH;
        end else if (sts.can_emit) begin
          cmd.emit = 1'b1;
          cmd.emit_sel = ESEL_CHAR;
          cmd.match_zero = 1'b1;
          state_next = S_FLUSH;
        end
      end
      S_RELD, S_FEEDC: begin
        if (state == S_RELD && !sts.rel_more) begin
          if (sts.c_eq_first) begin
            cmd.match_set1 = 1'b1;
            state_next = S_FLUSH;
          end else begin
            cmd.match_zero = 1'b1;
            state_next = S_FEEDC;
          end
        end else if (!(sts.f_complete && sts.f_bad && !sts.can_emit)) begin
          cmd.feed = 1'b1;
          cmd.rel_adv = (state == S_RELD);
          if (sts.f_complete && sts.f_bad) begin
            cmd.emit = 1'b1;
            cmd.emit_sel = ESEL_BAD;
          end
          if (sts.f_complete && !sts.f_bad) begin
            ret_rel_next = (state == S_RELD);
            state_next = S_DEC;
          end else if (state == S_FEEDC) begin
            state_next = S_FLUSH;
          end
        end
      end
      S_DEC: begin
        if (sts.can_emit) begin
          cmd.emit = 1'b1;
          cmd.emit_sel = ESEL_DEC;
          cmd.dec_adv = 1'b1;
          if (sts.dec_last) state_next = ret_rel ? S_RELD : S_FLUSH;
        end
      end
      S_NRD: begin
        cmd.name_rd = 1'b1;
        state_next = S_NOUT;
      end
      S_NOUT: begin
        if (sts.can_emit) begin
          cmd.emit = 1'b1;
          cmd.emit_sel = ESEL_NAME;
          cmd.name_adv = 1'b1;
          state_next = sts.name_last ? S_FLUSH : S_NRD;
        end
      end
      S_FLUSH: begin
        // mark the held result as the item's last transfer
        if (!sts.pend_valid) begin
          state_next = S_IDLE;
        end else if (sts.out_free) begin
          cmd.flush = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      ret_rel <= 1'b0;
    end else begin
      state   <= state_next;
      ret_rel <= ret_rel_next;
    end
  end

  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.can_emit)
    else $error("result pushed with no room");

  a_flush_room: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |-> (sts.out_free && sts.pend_valid))
    else $error("flush without held result or room");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !sts.pend_valid)
    else $error("held result left over at item boundary");

  a_data_entry: assert property (@(posedge clk) disable iff (rst)
    (cmd.mode_set && cmd.mode_val == MODE_DATA) |-> cmd.clear_xfer)
    else $error("data mode entered without clearing transfer state");

  a_emit_excl: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (state != S_IDLE) || $past(state == S_FLUSH) || !sts.pend_valid)
    else $error("result held across item boundary");

endmodule

>>> sv/marker_framed_base64_stream_demux_core.sv
// Top level of the marker-framed base64 stream demux: controller plus datapath.
// Depends on mfb64_pkg, mfb64_ctrl and mfb64_dp.
//
// channel  dir  handshake                  payload
// cfg      in   cfg_wr_en                  cfg_wr_data = idle_timeout_ticks
// s_axis   in   s_axis_tvalid/tready       tdata: data_byte, storage_ready; tuser: req_type
// m_axis   out  m_axis_tvalid/tready       tdata: value, byte_count; tuser: kind; tlast: last
//
// One item at a time: each item is captured in S_IDLE, dispatched in S_DISP and closed
// in S_FLUSH; a passed-through byte also goes through S_RELN and a data character through
// S_RELD and S_FEEDC, plus a step per held marker byte released and per decoded byte.
// A closing header adds an S_NRD and an S_NOUT step per filename byte (one header memory read each).
// rst is synchronous; it clears all control state and loads the timeout with 30000.
// Output back-pressure stalls the controller once one result is held and one is shown.
module marker_framed_base64_stream_demux_core #(
  parameter int HEADER_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] data_byte, [8] storage_ready, rest zero
  input  logic        s_axis_tuser,   // [0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [7:0] value, [39:8] byte_count
  output logic [2:0]  m_axis_tuser,   // [2:0] kind
  output logic        m_axis_tlast
);
  import mfb64_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic [7:0]  out_value;
  logic [31:0] out_count;

  mfb64_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mfb64_dp #(
    .HEADER_DEPTH (HEADER_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (s_axis_tdata),
    .in_tick     (s_axis_tuser),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .out_kind    (m_axis_tuser),
    .out_value   (out_value),
    .out_count   (out_count),
    .out_last    (m_axis_tlast)
  );

  assign m_axis_tdata = {out_count, out_value};

endmodule
